/* rtl/fcmac_pkg.sv */
// Shared constants, codes and structs of the fully connected MAC/bias/ReLU unit.
// Depends on nothing; every other file of the unit imports it.
package fcmac_pkg;

   localparam int MAX_VECTOR_LEN      = 1024;
   localparam int ADDR_W              = $clog2(MAX_VECTOR_LEN);
   localparam int DATA_W              = 16;
   localparam int PROD_W              = 2 * DATA_W;
   localparam int ACC_W               = 48;
   localparam int BIAS_W              = 32;
   localparam int RES_W               = 32;
   localparam int KIND_W              = 2;
   localparam int LEN_W               = 11;
   localparam int ROW_W               = 16;
   localparam int CSR_IDX_W           = 2;
   localparam int CSR_DATA_W          = 16;
   localparam int VECTOR_LENGTH_RESET = 1024;
   localparam int ROW_COUNT_RESET     = 1;

   // Output queue; the depth must be a power of two so the pointers wrap.
   localparam int OUTQ_DEPTH  = 4;
   localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
   localparam int MAC_STAGES  = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD      = 2'd0,
      KIND_ROW_START = 2'd1,
      KIND_WEIGHT    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VECTOR_LENGTH  = 2'd0,
      CSR_ROW_COUNT      = 2'd1,
      CSR_BIAS_RELU_MODE = 2'd2
   } csr_index_type;

   // One operation handed from the control to the MAC pipeline.
   typedef struct packed {
      logic              valid;
      logic              start;
      logic              use_bias;
      logic              mac;
      logic              emit;
      logic              clamp;
      logic [DATA_W-1:0] weight;
      logic [BIAS_W-1:0] bias;
      logic [ROW_W-1:0]  row_index;
      logic              last_row;
   } mac_op_type;

   // One finished row result on its way into the output queue.
   typedef struct packed {
      logic             valid;
      logic [RES_W-1:0] result;
      logic [ROW_W-1:0] row_index;
      logic             last_row;
   } res_push_type;

endpackage

/* rtl/fcmac_ifs.sv */
// Valid/ready channel interfaces of the fully connected MAC/bias/ReLU unit.
// Depends on fcmac_pkg for the field widths.
interface fcmac_req_if;
   import fcmac_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [DATA_W-1:0] value;
   logic signed [BIAS_W-1:0] bias;
   modport source (output valid, kind, value, bias, input ready);
   modport sink (input valid, kind, value, bias, output ready);
endinterface

interface fcmac_rsp_if;
   import fcmac_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RES_W-1:0] result;
   logic [ROW_W-1:0]        row_index;
   logic                    last_row;
   modport source (output valid, result, row_index, last_row, input ready);
   modport sink (input valid, result, row_index, last_row, output ready);
endinterface

interface fcmac_csr_if;
   import fcmac_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/fcmac_vstore.sv */
// Input vector store: one write port, one read port, registered read data.
// Depends on fcmac_pkg for depth and width.
module fcmac_vstore (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [fcmac_pkg::ADDR_W-1:0]       wr_addr,
   input  logic signed [fcmac_pkg::DATA_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic [fcmac_pkg::ADDR_W-1:0]       rd_addr,
   output logic signed [fcmac_pkg::DATA_W-1:0] rd_data
);
   import fcmac_pkg::*;

   logic signed [DATA_W-1:0] mem [MAX_VECTOR_LEN];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fcmac_mac.sv */
// Multiply-accumulate pipeline: product stage, accumulate stage, result shaping.
// Depends on fcmac_pkg; the element operand comes from fcmac_vstore.
module fcmac_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  fcmac_pkg::mac_op_type               op_in,
   input  logic signed [fcmac_pkg::DATA_W-1:0] elem,
   output fcmac_pkg::res_push_type             push,
   output logic [fcmac_pkg::MAC_STAGES-1:0]    emit_pending
);
   import fcmac_pkg::*;

   mac_op_type               s1_ff;
   mac_op_type               s2_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_next;
   logic signed [ACC_W:0]    sum;
   logic                     res_valid_ff;
   logic signed [ACC_W-1:0]  res_acc_ff;
   logic                     res_clamp_ff;
   logic [ROW_W-1:0]         res_row_ff;
   logic                     res_last_ff;
   logic signed [RES_W-1:0]  res_sat;

   // Stage 1: the element read at acceptance is now valid.
   assign prod_in = elem * $signed(s1_ff.weight);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else begin
         s1_ff <= op_in;
         s2_ff <= s1_ff;
      end
   end

   // Stage 2: accumulate with saturation at the accumulator width.
   always_comb begin
      sum = {acc_ff[ACC_W-1], acc_ff} + (ACC_W + 1)'(prod_ff);
      if (s2_ff.start) begin
         acc_next = s2_ff.use_bias ? ACC_W'($signed(s2_ff.bias)) : '0;
      end else if (s2_ff.mac) begin
         if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
         end else begin
            acc_next = sum[ACC_W-1:0];
         end
      end else begin
         acc_next = acc_ff;
      end
      if (!s2_ff.valid) begin
         acc_in = acc_ff;
      end else if (s2_ff.emit) begin
         acc_in = '0;
      end else begin
         acc_in = acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         res_valid_ff <= s2_ff.valid && s2_ff.emit;
      end
      res_acc_ff   <= acc_next;
      res_clamp_ff <= s2_ff.clamp;
      res_row_ff   <= s2_ff.row_index;
      res_last_ff  <= s2_ff.last_row;
   end

   // Stage 3: saturate to the result width, then clamp negatives in ReLU mode.
   always_comb begin
      if (res_acc_ff[ACC_W-1:RES_W-1] != {(ACC_W-RES_W+1){res_acc_ff[ACC_W-1]}}) begin
         res_sat = res_acc_ff[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
      end else begin
         res_sat = res_acc_ff[RES_W-1:0];
      end
      if (res_clamp_ff && res_sat[RES_W-1]) begin
         res_sat = '0;
      end
   end

   assign push.valid     = res_valid_ff;
   assign push.result    = res_sat;
   assign push.row_index = res_row_ff;
   assign push.last_row  = res_last_ff;

   assign emit_pending = {res_valid_ff, s2_ff.valid && s2_ff.emit, s1_ff.valid && s1_ff.emit};

endmodule

/* rtl/fcmac_outq.sv */
// Small output queue between the MAC pipeline and the result channel.
// Depends on fcmac_pkg and fcmac_ifs.
module fcmac_outq (
   input  logic                               clock,
   input  logic                               reset,
   input  fcmac_pkg::res_push_type            push,
   fcmac_rsp_if.source                        rsp,
   output logic [fcmac_pkg::OUTQ_CNT_W-1:0]   count
);
   import fcmac_pkg::*;

   res_push_type          entry_mem [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff;
   logic [OUTQ_CNT_W-1:0] count_ff;
   logic                  pop;

   assign pop = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_mem[wr_ptr_ff] <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push.valid && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push.valid) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign rsp.valid     = (count_ff != '0);
   assign rsp.result    = entry_mem[rd_ptr_ff].result;
   assign rsp.row_index = entry_mem[rd_ptr_ff].row_index;
   assign rsp.last_row  = entry_mem[rd_ptr_ff].last_row;
   assign count         = count_ff;

endmodule

/* rtl/fully_connected_mac_bias_relu_unit.sv */
// Top level of the fully connected MAC/bias/ReLU unit: control, registers, assertions.
// Depends on fcmac_pkg, fcmac_ifs, fcmac_vstore, fcmac_mac and fcmac_outq.

// This unit computes one fully connected layer a row at a time. Load items
// (kind 0) write the Q8.8 input vector into a 1024-entry store in order; the
// load pointer wraps after vector_length elements, so a new vector may be
// loaded at any time. A row-start item (kind 1) clears the accumulator, or
// in bias/ReLU mode loads it with the Q16.16 bias. The next vector_length
// weight items (kind 2) are each multiplied by the stored element at the
// column position and summed in a 48-bit accumulator; after the last one a
// single item leaves on the result channel, saturated to 32 bits and, in
// bias/ReLU mode, clamped at zero, tagged with its row index and a last-row
// flag. Kind 3 is ignored. The unit accepts an item each clock while the
// input is not stalled, set by the store ports and the one-product-per-cycle
// multiplier. The result of the weight that ends a row passes through the
// product, accumulate and result stages and then the output queue. The
// input stalls only when the four-entry output queue plus the results still
// in the three-stage MAC pipeline would fill it. The store needs no clearing
// after reset; an element must be loaded before a weight reads it. Registers
// are written through the csr channel, which is always ready; the user must
// write them only while the unit is idle, which the unit does not enforce.
module fully_connected_mac_bias_relu_unit (
   input  logic        clock,
   input  logic        reset,
   fcmac_req_if.sink   req_chan,
   fcmac_rsp_if.source rsp_chan,
   fcmac_csr_if.sink   csr_chan
);
   import fcmac_pkg::*;

   // Configuration registers.
   logic [LEN_W-1:0] vector_length_ff;
   logic [ROW_W-1:0] row_count_ff;
   logic             bias_relu_mode_ff;

   // Sequencing state.
   logic [ADDR_W-1:0] load_ff;
   logic [ADDR_W-1:0] load_in;
   logic [ADDR_W-1:0] col_ff;
   logic [ADDR_W-1:0] col_in;
   logic [ROW_W-1:0]  row_ff;
   logic [ROW_W-1:0]  row_in;

   logic [LEN_W-1:0]      len_eff;
   logic [ROW_W-1:0]      cnt_eff;
   logic                  accept;
   logic                  col_last;
   logic                  row_last;
   logic                  wr_en;
   logic                  rd_en;
   mac_op_type            op;
   res_push_type          res_push;
   logic signed [DATA_W-1:0] elem;
   logic [MAC_STAGES-1:0] emit_pending;
   logic [OUTQ_CNT_W-1:0] outq_count;
   logic [OUTQ_CNT_W:0]   outq_claim;

   // Out-of-range lengths act as the nearest legal value; a row count of
   // zero acts as one.
   always_comb begin
      if (vector_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (vector_length_ff > LEN_W'(MAX_VECTOR_LEN)) begin
         len_eff = LEN_W'(MAX_VECTOR_LEN);
      end else begin
         len_eff = vector_length_ff;
      end
      cnt_eff = (row_count_ff == '0) ? ROW_W'(1) : row_count_ff;
   end

   // Room for the new item's result is reserved before it is accepted, so
   // the MAC pipeline never has to stall.
   always_comb begin
      outq_claim = {1'b0, outq_count};
      for (int i = 0; i < MAC_STAGES; i++) begin
         outq_claim = outq_claim + (OUTQ_CNT_W + 1)'(emit_pending[i]);
      end
   end

   assign req_chan.ready = (outq_claim < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;

   // A column or row counter at or past its limit counts as the last one.
   assign col_last = ({1'b0, col_ff} + 1'b1) >= len_eff;
   assign row_last = ({1'b0, row_ff} + 1'b1) >= {1'b0, cnt_eff};

   always_comb begin
      load_in      = load_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      op.valid     = 1'b0;
      op.start     = 1'b0;
      op.use_bias  = bias_relu_mode_ff;
      op.mac       = 1'b0;
      op.emit      = 1'b0;
      op.clamp     = bias_relu_mode_ff;
      op.weight    = req_chan.value;
      op.bias      = req_chan.bias;
      op.row_index = row_ff;
      op.last_row  = row_last;
      if (accept) begin
         unique case (req_chan.kind)
            KIND_LOAD: begin
               wr_en = 1'b1;
               if (({1'b0, load_ff} + 1'b1) >= len_eff) begin
                  load_in = '0;
               end else begin
                  load_in = load_ff + 1'b1;
               end
            end
            KIND_ROW_START: begin
               op.valid = 1'b1;
               op.start = 1'b1;
               col_in   = '0;
            end
            KIND_WEIGHT: begin
               rd_en    = 1'b1;
               op.valid = 1'b1;
               op.mac   = 1'b1;
               if (col_last) begin
                  op.emit = 1'b1;
                  col_in  = '0;
                  row_in  = row_last ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         load_ff <= load_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   // Configuration writes; an index past the register list is dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff  <= LEN_W'(VECTOR_LENGTH_RESET);
         row_count_ff      <= ROW_W'(ROW_COUNT_RESET);
         bias_relu_mode_ff <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_VECTOR_LENGTH:  vector_length_ff  <= csr_chan.data[LEN_W-1:0];
            CSR_ROW_COUNT:      row_count_ff      <= csr_chan.data[ROW_W-1:0];
            CSR_BIAS_RELU_MODE: bias_relu_mode_ff <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   fcmac_vstore u_vstore (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_ff),
      .wr_data (req_chan.value),
      .rd_en   (rd_en),
      .rd_addr (col_ff),
      .rd_data (elem)
   );

   fcmac_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .op_in        (op),
      .elem         (elem),
      .push         (res_push),
      .emit_pending (emit_pending)
   );

   fcmac_outq u_outq (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .rsp   (rsp_chan),
      .count (outq_count)
   );

   // The reservation scheme must keep the queue from ever overflowing.
   a_outq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      res_push.valid |-> (outq_count < OUTQ_CNT_W'(OUTQ_DEPTH)))
      else $error("result pushed into a full output queue");

   // A weight that closes its row must start a result down the pipeline.
   a_row_end_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.kind == KIND_WEIGHT && col_last) |=> emit_pending[0])
      else $error("row end did not enter the MAC pipeline as a result");

   // Every result in the product stage must reach the queue through the accumulate and result stages.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      emit_pending[0] |-> ##2 res_push.valid)
      else $error("result lost inside the MAC pipeline");

   // A full queue must hold off the input.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (outq_count == OUTQ_CNT_W'(OUTQ_DEPTH)) |-> !req_chan.ready)
      else $error("input accepted while the output queue is full");

endmodule
